// File: sv/bch_pkg.sv
// ----------------------------------------------------------------------------
// bch_pkg
// Widths, register indexes, reset values and fixed constants of the block
// coefficient histogram.
// ----------------------------------------------------------------------------
package bch_pkg;

    // fixed field widths
    localparam int COEF_W     = 12;
    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int BS_W       = 7;
    localparam int REM_W      = 6;
    localparam int COUNT_W    = 13;
    localparam int TNUM_W     = 20;
    localparam int HIT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_CNT_W  = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [1:0]           t_div_op;

    // configuration register indexes
    localparam t_cfg_idx CFG_IMAGE_ROWS  = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_COLS  = 2'd1;
    localparam t_cfg_idx CFG_BLOCK_SIZE  = 2'd2;
    localparam t_cfg_idx CFG_CLASS_LABEL = 2'd3;

    // operands of the shared divider, in the order they are worked
    localparam t_div_op DIV_OP_ROWS = 2'd0;
    localparam t_div_op DIV_OP_COLS = 2'd1;
    localparam t_div_op DIV_OP_ROW  = 2'd2;
    localparam t_div_op DIV_OP_COL  = 2'd3;

    // register reset values and limits
    localparam logic [DIM_W-1:0] RST_IMAGE_ROWS = 13'd256;
    localparam logic [DIM_W-1:0] RST_IMAGE_COLS = 13'd256;
    localparam logic [BS_W-1:0]  RST_BLOCK_SIZE = 7'd32;
    localparam logic [DIM_W-1:0] DIM_MAX        = 13'd4096;
    localparam logic [BS_W-1:0]  BS_MAX         = 7'd64;

    // coefficient value range that is counted is -BIN_OFFSET..BIN_OFFSET
    localparam logic signed [COEF_W-1:0] BIN_OFFSET = 12'sd5;

    // one quotient bit per step over a dimension-wide dividend
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 4'(DIM_W - 1);

endpackage

// File: sv/block_coefficient_histogram.sv
// ----------------------------------------------------------------------------
// block_coefficient_histogram
// Per-tile, per-channel histograms of quantized coefficients in -5..5.
// ----------------------------------------------------------------------------
// Usage:
// Coefficients enter on i_in_valid / o_in_stall in raster order, CHANNELS per
// position. A transaction is taken when valid is high and stall is low.
// Histograms leave on o_out_valid / i_out_stall, one transaction per bin with
// o_last on the final bin of a channel. Geometry and label are written on the
// configuration port (always ready); the user must write them only while the
// block is idle, which the block does not enforce. Each coefficient passes
// accept, multiply and update and, if it hits a bin of a tile, memory read
// and memory write, a single-port read-modify-write of the count memory;
// o_in_stall is high until it is through. The first coefficient after reset
// or a configuration write waits while the shared serial divider derives the
// tile counts and the tile coordinates of the current position.
// A tile-closing coefficient reads and clears each bin in turn, held by
// i_out_stall; the output register lets the last bin wait while the next
// coefficient is taken. Reset: a clearing pass, with o_in_stall high, zeroes
// the MAX_TILES_PER_ROW * CHANNELS * BINS (6336 by default) memory entries.
// ----------------------------------------------------------------------------
module block_coefficient_histogram #(
    parameter int MAX_TILES_PER_ROW = 64,
    parameter int CHANNELS          = 9,
    parameter int BINS              = 11,
    localparam int CW               = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int BW               = $clog2(BINS)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // coefficient channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [bch_pkg::COEF_W-1:0]   i_coefficient,
    // histogram channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bch_pkg::TNUM_W-1:0]          o_tile_number,
    output logic [CW-1:0]                       o_channel,
    output logic [BW-1:0]                       o_bin,
    output logic [bch_pkg::COUNT_W-1:0]         o_bin_count,
    output logic                                o_label,
    output logic                                o_last,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bch_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bch_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int DEPTH = MAX_TILES_PER_ROW * CHANNELS * BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TPW   = $clog2(MAX_TILES_PER_ROW + 1);

    localparam logic [AW-1:0]  SLOT_STRIDE = AW'(CHANNELS * BINS);
    localparam logic [AW-1:0]  BIN_STRIDE  = AW'(BINS);
    localparam logic [AW-1:0]  LAST_ADDR   = AW'(DEPTH - 1);
    localparam logic [BW-1:0]  LAST_BIN    = BW'(BINS - 1);
    localparam logic [TPW-1:0] TPR_MAX     = TPW'(MAX_TILES_PER_ROW);

    // sequencer states
    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DIV_LD  = 4'd2;
    localparam logic [3:0] ST_DIV_RUN = 4'd3;
    localparam logic [3:0] ST_MUL     = 4'd4;
    localparam logic [3:0] ST_CALC    = 4'd5;
    localparam logic [3:0] ST_RD      = 4'd6;
    localparam logic [3:0] ST_WR      = 4'd7;
    localparam logic [3:0] ST_EMIT_RD = 4'd8;
    localparam logic [3:0] ST_EMIT_LD = 4'd9;

    logic [3:0] r_state, n_state;

    // configuration registers
    logic [bch_pkg::DIM_W-1:0] r_rows, r_cols;
    logic [bch_pkg::BS_W-1:0]  r_bs;
    logic                      r_label;
    logic                      r_dirty;

    // shared divider
    logic [1:0]                    r_op;
    logic [bch_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [bch_pkg::DIM_W-1:0]     r_quo;
    logic [bch_pkg::BS_W-1:0]      r_rem;

    // tiling derived from the registers and the current position
    logic [bch_pkg::DIM_W-1:0] r_tile_rows;
    logic [TPW-1:0]            r_tpr;
    logic [bch_pkg::POS_W-1:0] r_tr, r_tc;
    logic [bch_pkg::REM_W-1:0] r_rr, r_cr;

    // position and tile numbering
    logic [bch_pkg::POS_W-1:0]  r_row_pos, r_col_pos;
    logic [CW-1:0]              r_ch_pos;
    logic [bch_pkg::TNUM_W-1:0] r_tile_base;

    // per-coefficient working registers
    logic signed [bch_pkg::COEF_W-1:0] r_coef;
    logic [bch_pkg::TNUM_W-1:0]        r_prod, r_img_tiles, r_tnum;
    logic                              r_in_tile, r_tile_end, r_hit;
    logic [BW-1:0]                     r_hit_bin, r_emit_b;
    logic [AW-1:0]                     r_base, r_clr;
    logic [CW-1:0]                     r_ch_cap;

    // count memory
    logic [bch_pkg::COUNT_W-1:0] mem [DEPTH];
    logic [bch_pkg::COUNT_W-1:0] r_rdata;
    logic                        w_mem_we, w_mem_re;
    logic [AW-1:0]               w_mem_addr;
    logic [bch_pkg::COUNT_W-1:0] w_mem_wdata;

    // output register
    logic                        r_out_valid;
    logic [bch_pkg::TNUM_W-1:0]  r_out_tnum;
    logic [CW-1:0]               r_out_ch;
    logic [BW-1:0]               r_out_bin;
    logic [bch_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_label, r_out_last;

    logic w_in_accept, w_cfg_write, w_out_free, w_out_load;

    // clamped registers
    logic [bch_pkg::DIM_W-1:0] w_rows, w_cols;
    logic [bch_pkg::BS_W-1:0]  w_bs;

    // divider step
    logic [bch_pkg::DIM_W-1:0] w_dividend;
    logic [bch_pkg::BS_W:0]    w_trial;
    logic                      w_ge;
    logic [bch_pkg::DIM_W-1:0] w_quo_nx;
    logic [bch_pkg::BS_W-1:0]  w_rem_nx;
    logic [TPW-1:0]            w_tpr_clamped;

    // bin decode
    logic                      w_in_range, w_hit_ok;
    logic [bch_pkg::HIT_W-1:0] w_hit_raw;

    // position advance
    logic w_ch_wrap, w_col_wrap, w_row_wrap, w_cr_wrap, w_rr_wrap;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = (r_state == ST_EMIT_LD) && w_out_free;

    // register clamping: zero reads as one, oversize reads as the limit
    always_comb begin
        w_rows = (r_rows == '0) ? 13'd1 :
                 ((r_rows > bch_pkg::DIM_MAX) ? bch_pkg::DIM_MAX : r_rows);
        w_cols = (r_cols == '0) ? 13'd1 :
                 ((r_cols > bch_pkg::DIM_MAX) ? bch_pkg::DIM_MAX : r_cols);
        w_bs   = (r_bs == '0) ? 7'd1 :
                 ((r_bs > bch_pkg::BS_MAX) ? bch_pkg::BS_MAX : r_bs);
    end

    // dividend select and one restoring division step
    always_comb begin
        unique case (r_op)
            bch_pkg::DIV_OP_ROWS: w_dividend = w_rows;
            bch_pkg::DIV_OP_COLS: w_dividend = w_cols;
            bch_pkg::DIV_OP_ROW:  w_dividend = {1'b0, r_row_pos};
            bch_pkg::DIV_OP_COL:  w_dividend = {1'b0, r_col_pos};
            default:              w_dividend = '0;
        endcase
        w_trial       = {r_rem, r_quo[bch_pkg::DIM_W-1]};
        w_ge          = (w_trial >= {1'b0, w_bs});
        w_quo_nx      = {r_quo[bch_pkg::DIM_W-2:0], w_ge};
        w_rem_nx      = w_ge ? bch_pkg::BS_W'(w_trial - {1'b0, w_bs})
                             : w_trial[bch_pkg::BS_W-1:0];
        w_tpr_clamped = (w_quo_nx > bch_pkg::DIM_W'(MAX_TILES_PER_ROW)) ? TPR_MAX
                                                                      : TPW'(w_quo_nx);
    end

    // coefficient to bin
    always_comb begin
        w_in_range = (r_coef >= -bch_pkg::BIN_OFFSET) && (r_coef <= bch_pkg::BIN_OFFSET);
        w_hit_raw  = bch_pkg::HIT_W'(r_coef[bch_pkg::HIT_W-1:0]
                                     + bch_pkg::HIT_W'(bch_pkg::BIN_OFFSET));
        w_hit_ok   = w_in_range && ({1'b0, w_hit_raw} < 5'(BINS));
    end

    // wrap conditions of the position counters
    always_comb begin
        w_ch_wrap  = ((CW + 1)'(r_ch_pos) + (CW + 1)'(1)) >= (CW + 1)'(CHANNELS);
        w_col_wrap = (bch_pkg::DIM_W'(r_col_pos) + 13'd1) >= w_cols;
        w_row_wrap = (bch_pkg::DIM_W'(r_row_pos) + 13'd1) >= w_rows;
        w_cr_wrap  = ({1'b0, r_cr} + 7'd1) == w_bs;
        w_rr_wrap  = ({1'b0, r_rr} + 7'd1) == w_bs;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:   if (r_clr == LAST_ADDR) n_state = ST_IDLE;
            ST_IDLE:    if (w_in_accept) n_state = r_dirty ? ST_DIV_LD : ST_MUL;
            ST_DIV_LD:  n_state = ST_DIV_RUN;
            ST_DIV_RUN: begin
                if (r_cnt == bch_pkg::DIV_LAST_STEP) begin
                    n_state = (r_op == bch_pkg::DIV_OP_COL) ? ST_MUL : ST_DIV_LD;
                end
            end
            ST_MUL:     n_state = ST_CALC;
            ST_CALC: begin
                if (r_in_tile && r_hit)           n_state = ST_RD;
                else if (r_in_tile && r_tile_end) n_state = ST_EMIT_RD;
                else                              n_state = ST_IDLE;
            end
            ST_RD:      n_state = ST_WR;
            ST_WR:      n_state = r_tile_end ? ST_EMIT_RD : ST_IDLE;
            ST_EMIT_RD: n_state = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (w_out_free) n_state = (r_emit_b == LAST_BIN) ? ST_IDLE : ST_EMIT_RD;
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = r_base + AW'(r_emit_b);
        w_mem_wdata = '0;
        unique case (r_state)
            ST_CLEAR: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_clr;
            end
            ST_RD: begin
                w_mem_re   = 1'b1;
                w_mem_addr = r_base + AW'(r_hit_bin);
            end
            ST_WR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = r_base + AW'(r_hit_bin);
                w_mem_wdata = r_rdata + 13'd1;
            end
            ST_EMIT_RD: w_mem_re = 1'b1;
            ST_EMIT_LD: w_mem_we = w_out_free;
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // count memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= mem[w_mem_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_dirty     <= 1'b1;
            r_rows      <= bch_pkg::RST_IMAGE_ROWS;
            r_cols      <= bch_pkg::RST_IMAGE_COLS;
            r_bs        <= bch_pkg::RST_BLOCK_SIZE;
            r_label     <= 1'b0;
            r_row_pos   <= '0;
            r_col_pos   <= '0;
            r_ch_pos    <= '0;
            r_tile_base <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // clearing pass after reset
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end

            // configuration writes
            if (w_cfg_write) begin
                r_dirty <= 1'b1;
                case (i_cfg_index)
                    bch_pkg::CFG_IMAGE_ROWS:  r_rows  <= i_cfg_data;
                    bch_pkg::CFG_IMAGE_COLS:  r_cols  <= i_cfg_data;
                    bch_pkg::CFG_BLOCK_SIZE:  r_bs    <= i_cfg_data[bch_pkg::BS_W-1:0];
                    bch_pkg::CFG_CLASS_LABEL: r_label <= i_cfg_data[0];
                    default:                  r_label <= r_label;
                endcase
            end else if (r_state == ST_DIV_RUN && r_cnt == bch_pkg::DIV_LAST_STEP &&
                         r_op == bch_pkg::DIV_OP_COL) begin
                r_dirty <= 1'b0;
            end

            // position advance once the tile coordinates are used
            if (r_state == ST_CALC) begin
                if (w_ch_wrap) begin
                    r_ch_pos <= '0;
                    if (w_col_wrap) begin
                        r_col_pos <= '0;
                        if (w_row_wrap) begin
                            r_row_pos   <= '0;
                            r_tile_base <= r_tile_base + r_img_tiles;
                        end else begin
                            r_row_pos <= r_row_pos + 12'd1;
                        end
                    end else begin
                        r_col_pos <= r_col_pos + 12'd1;
                    end
                end else begin
                    r_ch_pos <= r_ch_pos + CW'(1);
                end
            end

            // output register handshake
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_coef <= i_coefficient;
            r_op   <= bch_pkg::DIV_OP_ROWS;
        end

        // shared divider: load, step, store result
        if (r_state == ST_DIV_LD) begin
            r_quo <= w_dividend;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (r_state == ST_DIV_RUN) begin
            r_quo <= w_quo_nx;
            r_rem <= w_rem_nx;
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == bch_pkg::DIV_LAST_STEP) begin
                r_op <= r_op + 2'd1;
                unique case (r_op)
                    bch_pkg::DIV_OP_ROWS: r_tile_rows <= w_quo_nx;
                    bch_pkg::DIV_OP_COLS: r_tpr <= w_tpr_clamped;
                    bch_pkg::DIV_OP_ROW: begin
                        r_tr <= w_quo_nx[bch_pkg::POS_W-1:0];
                        r_rr <= w_rem_nx[bch_pkg::REM_W-1:0];
                    end
                    bch_pkg::DIV_OP_COL: begin
                        r_tc <= w_quo_nx[bch_pkg::POS_W-1:0];
                        r_cr <= w_rem_nx[bch_pkg::REM_W-1:0];
                    end
                    default: r_tpr <= r_tpr;
                endcase
            end
        end

        // products and tile checks
        if (r_state == ST_MUL) begin
            r_prod      <= bch_pkg::TNUM_W'({8'd0, r_tr} * bch_pkg::TNUM_W'(r_tpr));
            r_img_tiles <= bch_pkg::TNUM_W'(bch_pkg::TNUM_W'(r_tile_rows)
                                            * bch_pkg::TNUM_W'(r_tpr));
            r_in_tile   <= ({1'b0, r_tr} < r_tile_rows) &&
                           ({1'b0, r_tc} < bch_pkg::DIM_W'(r_tpr));
            r_tile_end  <= ({1'b0, r_rr} == w_bs - 7'd1) && ({1'b0, r_cr} == w_bs - 7'd1);
            r_hit       <= w_hit_ok;
            r_hit_bin   <= BW'(w_hit_raw);
        end

        // tile number, slot address, incremental tile coordinates
        if (r_state == ST_CALC) begin
            r_tnum   <= r_tile_base + r_prod + bch_pkg::TNUM_W'(r_tc);
            r_base   <= AW'(AW'(r_tc) * SLOT_STRIDE) + AW'(AW'(r_ch_pos) * BIN_STRIDE);
            r_ch_cap <= r_ch_pos;
            r_emit_b <= '0;
            if (w_ch_wrap) begin
                if (w_col_wrap) begin
                    r_tc <= '0;
                    r_cr <= '0;
                    if (w_row_wrap) begin
                        r_tr <= '0;
                        r_rr <= '0;
                    end else if (w_rr_wrap) begin
                        r_tr <= r_tr + 12'd1;
                        r_rr <= '0;
                    end else begin
                        r_rr <= r_rr + 6'd1;
                    end
                end else if (w_cr_wrap) begin
                    r_tc <= r_tc + 12'd1;
                    r_cr <= '0;
                end else begin
                    r_cr <= r_cr + 6'd1;
                end
            end
        end

        // histogram drain into the output register
        if (w_out_load) begin
            r_out_tnum  <= r_tnum;
            r_out_ch    <= r_ch_cap;
            r_out_bin   <= r_emit_b;
            r_out_count <= r_rdata;
            r_out_label <= r_label;
            r_out_last  <= (r_emit_b == LAST_BIN);
            r_emit_b    <= r_emit_b + BW'(1);
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_tile_number = r_out_tnum;
    assign o_channel     = r_out_ch;
    assign o_bin         = r_out_bin;
    assign o_bin_count   = r_out_count;
    assign o_label       = r_out_label;
    assign o_last        = r_out_last;

endmodule
